// File: rtl/swms_pkg.sv
package swms_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int LEN_BITS    = 7;
   localparam int SUM_BITS    = 64;
   localparam int AGE_BITS    = $clog2(MAX_WINDOW + 1);

   typedef logic [AGE_BITS-1:0] age_type;
   typedef logic [AGE_BITS:0]   age_ext_type;

   typedef struct packed {
      logic                          valid;
      logic signed [SAMPLE_BITS-1:0] value;
      age_type                       age;
   } entry_type;

   typedef struct packed {
      logic step;
      logic trim;
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic trim_needed;
   } chain_stat_type;

endpackage

// File: rtl/swms_cell.sv
module swms_cell (
   input  logic                                    clock,
   input  logic                                    reset,
   input  swms_pkg::cell_ctrl_type                 ctrl,
   input  logic signed [swms_pkg::SAMPLE_BITS-1:0] sample,
   input  swms_pkg::entry_type                     right_entry,
   input  logic                                    right_keep,
   input  logic                                    left_keep,
   output swms_pkg::entry_type                     entry,
   output logic                                    keep
);

   swms_pkg::entry_type entry_ff;
   swms_pkg::entry_type entry_in;
   swms_pkg::entry_type src;
   logic                own_keep;
   logic                src_keep;
   logic                prev_keep;

   // An entry survives the word when it is smaller than the new sample.
   assign own_keep  = entry_ff.valid && ($signed(entry_ff.value) < sample) && !ctrl.clear;
   assign src       = ctrl.shift ? right_entry : entry_ff;
   assign src_keep  = ctrl.shift ? right_keep : own_keep;
   assign prev_keep = left_keep;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.trim) begin
         entry_in = right_entry;
      end else if (ctrl.step) begin
         if (src_keep) begin
            entry_in     = src;
            entry_in.age = swms_pkg::age_type'(src.age + 1'b1);
         end else if (prev_keep) begin
            entry_in.valid = 1'b1;
            entry_in.value = sample;
            entry_in.age   = '0;
         end else begin
            entry_in.valid = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;
   assign keep  = own_keep;

endmodule

// File: rtl/swms_chain.sv
module swms_chain (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step,
   input  logic                                    clear,
   input  logic signed [swms_pkg::SAMPLE_BITS-1:0] sample,
   input  swms_pkg::age_type                       window,
   output logic signed [swms_pkg::SAMPLE_BITS-1:0] front_value,
   output swms_pkg::chain_stat_type                stat
);

   swms_pkg::entry_type     cells [swms_pkg::MAX_WINDOW];
   logic                    keep  [swms_pkg::MAX_WINDOW];
   swms_pkg::cell_ctrl_type ctrl;
   logic                    front_aged;
   logic                    second_aged;

   // The oldest entry sits in cell 0; an entry is out of the window once its
   // age after this word reaches the window length.
   assign front_aged  = cells[0].valid && ((swms_pkg::age_ext_type'(cells[0].age) + 1'b1)
                        >= swms_pkg::age_ext_type'(window));
   assign second_aged = cells[1].valid && ((swms_pkg::age_ext_type'(cells[1].age) + 1'b1)
                        >= swms_pkg::age_ext_type'(window));

   assign ctrl.step  = step;
   assign ctrl.clear = clear;
   assign ctrl.shift = front_aged;
   assign ctrl.trim  = second_aged && !step;

   assign stat.trim_needed = second_aged;

   for (genvar i = 0; i < swms_pkg::MAX_WINDOW; i++) begin : g_cell
      swms_pkg::entry_type right_entry;
      logic                right_keep;
      logic                left_keep;

      if (i == swms_pkg::MAX_WINDOW - 1) begin : g_last
         assign right_entry = '0;
         assign right_keep  = 1'b0;
      end else begin : g_mid
         assign right_entry = cells[i+1];
         assign right_keep  = keep[i+1];
      end

      // When the front shifts out, the left neighbor of a cell's new entry is
      // its own old entry, and cell 0 always borders the front.
      if (i == 0) begin : g_first
         assign left_keep = 1'b1;
      end else begin : g_rest
         assign left_keep = ctrl.shift ? keep[i] : keep[i-1];
      end

      swms_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .sample      (sample),
         .right_entry (right_entry),
         .right_keep  (right_keep),
         .left_keep   (left_keep),
         .entry       (cells[i]),
         .keep        (keep[i])
      );
   end

   always_comb begin
      if (front_aged) begin
         front_value = keep[1] ? cells[1].value : sample;
      end else begin
         front_value = keep[0] ? cells[0].value : sample;
      end
   end

   a_front_ordered: assert property (@(posedge clock) disable iff (reset)
      (cells[0].valid && cells[1].valid) |-> ($signed(cells[0].value) < $signed(cells[1].value)))
      else $error("deque front entries out of order");

   a_front_in_window: assert property (@(posedge clock) disable iff (reset)
      step |=> (cells[0].valid &&
                (swms_pkg::age_ext_type'(cells[0].age) < swms_pkg::age_ext_type'($past(window)))))
      else $error("deque front missing or outside window after a sample");

endmodule

// File: rtl/sliding_window_minimum_sum.sv
// A result word is registered and appears in the cycle after its sample is accepted.
// Throughput: one sample per cycle while req_stall is low; the cell row compares all entries in parallel.
// After the window length is made shorter, the row drops one front entry per cycle until
// no more than one entry can age out, and requests are stalled meanwhile.
// Reset is synchronous: it empties the deque, clears the counters and sum, sets length 1.
module sliding_window_minimum_sum (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [swms_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                    req_start_req,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [swms_pkg::SAMPLE_BITS-1:0] rsp_window_min,
   output logic signed [swms_pkg::SUM_BITS-1:0]    rsp_running_sum,
   input  logic                                    csr_write_enable,
   input  logic [swms_pkg::LEN_BITS-1:0]           csr_write_data
);

   logic [swms_pkg::LEN_BITS-1:0]           window_len_ff;
   swms_pkg::age_type                       window;
   swms_pkg::age_type                       count_ff;
   swms_pkg::age_type                       count_in;
   swms_pkg::age_type                       count_cur;
   logic                                    full_ff;
   logic                                    full_in;
   logic [swms_pkg::SUM_BITS-1:0]           sum_ff;
   logic [swms_pkg::SUM_BITS-1:0]           sum_in;
   logic                                    rsp_valid_ff;
   logic                                    rsp_valid_in;
   logic signed [swms_pkg::SAMPLE_BITS-1:0] min_ff;
   logic signed [swms_pkg::SAMPLE_BITS-1:0] front_value;
   swms_pkg::chain_stat_type                stat;
   logic                                    accept;

   always_comb begin
      if (window_len_ff == '0) begin
         window = swms_pkg::age_type'(1);
      end else if (int'(window_len_ff) > swms_pkg::MAX_WINDOW) begin
         window = swms_pkg::age_type'(swms_pkg::MAX_WINDOW);
      end else begin
         window = swms_pkg::age_type'(window_len_ff);
      end
   end

   assign req_stall = reset || stat.trim_needed || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   swms_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .clear       (req_start_req),
      .sample      (req_sample),
      .window      (window),
      .front_value (front_value),
      .stat        (stat)
   );

   always_comb begin
      count_cur = req_start_req ? '0 : count_ff;
      full_in   = (full_ff && !req_start_req) ||
                  ((swms_pkg::age_ext_type'(count_cur) + 1'b1) >= swms_pkg::age_ext_type'(window));
      if (int'(count_cur) == swms_pkg::MAX_WINDOW) begin
         count_in = count_cur;
      end else begin
         count_in = swms_pkg::age_type'(count_cur + 1'b1);
      end
      sum_in = req_start_req ? '0 : sum_ff;
      if (full_in) begin
         sum_in = sum_in + swms_pkg::SUM_BITS'(front_value);
      end
      if (accept) begin
         rsp_valid_in = full_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= swms_pkg::LEN_BITS'(1);
         count_ff      <= '0;
         full_ff       <= 1'b0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_len_ff <= csr_write_data;
         end
         if (accept) begin
            count_ff <= count_in;
            full_ff  <= full_in;
            sum_ff   <= sum_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && full_in) begin
         min_ff <= front_value;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_min  = min_ff;
   assign rsp_running_sum = $signed(sum_ff);

   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("result word appeared without an accepted sample");

   a_no_accept_while_trim: assert property (@(posedge clock) disable iff (reset)
      stat.trim_needed |-> !accept)
      else $error("sample accepted while the deque front was being trimmed");

endmodule

// File: tb/sliding_window_minimum_sum_test.sv
module sliding_window_minimum_sum_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WINDOW    = swms_pkg::MAX_WINDOW;
   localparam int SAMPLE_BITS   = swms_pkg::SAMPLE_BITS;
   localparam int LEN_BITS      = swms_pkg::LEN_BITS;
   localparam int SUM_BITS      = swms_pkg::SUM_BITS;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 80;
   localparam int HEAD_BITS     = $clog2(MAX_WINDOW);
   localparam int RANDOM_ITEMS  = 1050;
   localparam logic signed [SAMPLE_BITS-1:0] MOST_POSITIVE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum int {FULL_RATE, SENDER_GAPS, RECEIVER_STALLS, BOTH_IDLE} traffic_type;
   typedef enum int {
      WIDE_VALUES, NARROW_VALUES, RISING_RUN, FALLING_RUN, EXTREME_VALUES
   } pattern_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          start;
   } sample_word_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] window_min;
      logic signed [SUM_BITS-1:0]    running_sum;
   } min_result_type;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample       = '0;
   logic                          req_start_req    = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_window_min;
   logic signed [SUM_BITS-1:0]    rsp_running_sum;
   logic                          csr_write_enable = 1'b0;
   logic [LEN_BITS-1:0]           csr_write_data   = '0;

   sample_word_type pending_q[$];
   min_result_type  expected_min_q[$];
   int              queued_count   = 0;
   int              accepted_count = 0;
   int              error_count    = 0;
   int              cycle_count    = 0;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;

   // Predictor copy of the candidate deque and the counters.
   logic [LEN_BITS-1:0]           model_len = 1;
   logic signed [SAMPLE_BITS-1:0] cand_value [MAX_WINDOW];
   logic [31:0]                   cand_index [MAX_WINDOW];
   logic [HEAD_BITS-1:0]          cand_head = '0;
   logic [HEAD_BITS:0]            cand_count = '0;
   logic [31:0]                   seq_index = '0;
   logic [SUM_BITS-1:0]           min_total = '0;
   logic                          window_full = 1'b0;

   sliding_window_minimum_sum dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_start_req    (req_start_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_min   (rsp_window_min),
      .rsp_running_sum  (rsp_running_sum),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   task automatic predict_window(input logic signed [SAMPLE_BITS-1:0] s, input logic start);
      logic [31:0]                   span;
      logic [HEAD_BITS-1:0]          slot_at;
      logic signed [SAMPLE_BITS-1:0] front;
      min_result_type                res;
      if (model_len == 0) begin
         span = 1;
      end else if (model_len > MAX_WINDOW) begin
         span = MAX_WINDOW;
      end else begin
         span = 32'(model_len);
      end
      if (start) begin
         cand_head   = '0;
         cand_count  = '0;
         seq_index   = '0;
         min_total   = '0;
         window_full = 1'b0;
      end
      while (cand_count != 0 && (seq_index - cand_index[cand_head]) >= span) begin
         cand_head  = cand_head + 1'b1;
         cand_count = cand_count - 1'b1;
      end
      slot_at = cand_head + cand_count[HEAD_BITS-1:0] - 1'b1;
      while (cand_count != 0 && cand_value[slot_at] >= s) begin
         cand_count = cand_count - 1'b1;
         slot_at    = slot_at - 1'b1;
      end
      if (cand_count >= MAX_WINDOW) begin
         cand_head  = cand_head + 1'b1;
         cand_count = cand_count - 1'b1;
      end
      slot_at             = cand_head + cand_count[HEAD_BITS-1:0];
      cand_value[slot_at] = s;
      cand_index[slot_at] = seq_index;
      cand_count          = cand_count + 1'b1;
      if (seq_index >= span - 1) begin
         window_full = 1'b1;
      end
      seq_index = seq_index + 1;
      if (window_full) begin
         front     = cand_value[cand_head];
         min_total = min_total + {{(SUM_BITS-SAMPLE_BITS){front[SAMPLE_BITS-1]}}, front};
         res.window_min  = front;
         res.running_sum = min_total;
         expected_min_q  = {expected_min_q, res};
      end
   endtask

   task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic start);
      sample_word_type w;
      w.sample  = s;
      w.start   = start;
      pending_q = {pending_q, w};
      queued_count++;
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || expected_min_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window_len(input logic [LEN_BITS-1:0] len);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_len = len;
   endtask

   task automatic set_traffic(input traffic_type mode);
      case (mode)
         FULL_RATE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         SENDER_GAPS: begin
            send_idle_pct  = 65;
            recv_stall_pct = 0;
         end
         RECEIVER_STALLS: begin
            send_idle_pct  = 0;
            recv_stall_pct = 65;
         end
         default: begin
            send_idle_pct  = 36;
            recv_stall_pct = 36;
         end
      endcase
   endtask

   always @(posedge clock) begin : drive_requests
      sample_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_window(req_sample, req_start_req);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = pending_q[0];
               pending_q.delete(0);
               req_valid     <= 1'b1;
               req_sample    <= next_word.sample;
               req_start_req <= next_word.start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      min_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_min_q.size() == 0) begin
               $display("%0t: unexpected result word, window_min %0d running_sum %0d",
                        $time, rsp_window_min, rsp_running_sum);
               error_count++;
            end else begin
               want = expected_min_q[0];
               expected_min_q.delete(0);
               if (rsp_window_min !== want.window_min) begin
                  $display("%0t: window_min expected %0d actual %0d",
                           $time, want.window_min, rsp_window_min);
                  error_count++;
               end
               if (rsp_running_sum !== want.running_sum) begin
                  $display("%0t: running_sum expected %0d actual %0d",
                           $time, want.running_sum, rsp_running_sum);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL sliding_window_minimum_sum");
         $finish;
      end
   end

   initial begin : stimulus
      int                            phase;
      int                            count;
      int                            run_len;
      int                            random_goal;
      pattern_type                   pattern;
      logic signed [SAMPLE_BITS-1:0] level;
      logic [LEN_BITS-1:0]           len_choice;
      logic                          first;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Window length left at its reset value of one.
      set_traffic(FULL_RATE);
      queue_sample(MOST_POSITIVE, 1'b1);
      queue_sample(MOST_NEGATIVE, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(-1, 1'b0);
      queue_sample(1, 1'b0);

      // Equal values, falling values and aging out of a four-sample window.
      write_window_len(4);
      queue_sample(5, 1'b1);
      queue_sample(3, 1'b0);
      queue_sample(3, 1'b0);
      queue_sample(7, 1'b0);
      queue_sample(2, 1'b0);
      queue_sample(2, 1'b0);
      queue_sample(9, 1'b0);
      queue_sample(9, 1'b0);
      queue_sample(10, 1'b0);
      queue_sample(-8, 1'b1);
      queue_sample(8, 1'b0);
      queue_sample(8, 1'b0);
      queue_sample(8, 1'b0);

      // A zero length acts as one and shrinks the live window.
      write_window_len(0);
      queue_sample(4, 1'b0);
      queue_sample(-4, 1'b0);
      queue_sample(4, 1'b0);

      // An oversized length is clamped to the deque depth.
      write_window_len({LEN_BITS{1'b1}});
      queue_sample(MOST_POSITIVE, 1'b0);
      queue_sample(MOST_NEGATIVE, 1'b0);
      queue_sample(MOST_POSITIVE, 1'b0);
      queue_sample(MOST_POSITIVE, 1'b0);

      random_goal = queued_count + RANDOM_ITEMS;
      phase = 0;
      while (queued_count < random_goal) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: len_choice = LEN_BITS'($urandom_range(8, 1));
            5:             len_choice = LEN_BITS'($urandom_range(MAX_WINDOW - 1, 9));
            6:             len_choice = LEN_BITS'(MAX_WINDOW);
            7:             len_choice = LEN_BITS'($urandom_range(127, MAX_WINDOW + 1));
            8:             len_choice = '0;
            default:       len_choice = LEN_BITS'(1);
         endcase
         write_window_len(len_choice);
         set_traffic(traffic_type'(phase % 4));
         count = $urandom_range(100, 20);
         first = ($urandom_range(1) == 1);
         while (count > 0) begin
            pattern = pattern_type'($urandom_range(4));
            if (pattern == RISING_RUN || pattern == FALLING_RUN) begin
               run_len = $urandom_range(80, 1);
            end else begin
               run_len = $urandom_range(12, 1);
            end
            level = $urandom;
            repeat (run_len) begin
               case (pattern)
                  WIDE_VALUES:   level = $urandom;
                  NARROW_VALUES: level = $urandom_range(8) - 4;
                  RISING_RUN:    level = level + $urandom_range(3, 1);
                  FALLING_RUN:   level = level - $urandom_range(3, 1);
                  default: begin
                     case ($urandom_range(3))
                        0:       level = MOST_NEGATIVE;
                        1:       level = MOST_POSITIVE;
                        2:       level = 0;
                        default: level = -1;
                     endcase
                  end
               endcase
               queue_sample(level, first || $urandom_range(49) == 0);
               first = 1'b0;
               count--;
            end
         end
         phase++;
      end

      wait_drained();
      if (error_count == 0) begin
         $display("PASS sliding_window_minimum_sum");
      end else begin
         $display("FAIL sliding_window_minimum_sum");
      end
      $finish;
   end

endmodule
